FILE: sv/vbsc_pkg.sv
// shared types, constants and helper functions for the block slot cache
package vbsc_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int CFG_W          = 6;
	localparam int OP_W           = 3;
	localparam int BLK_W          = 16;
	localparam int USE_W          = 16;
	localparam int AGE_W          = 32;
	localparam int CRD_W          = 16;
	localparam int TRN_W          = 8;
	localparam int TILE_W         = 12;

	localparam logic [CFG_W-1:0]  MAX_IN_USE       = 6'h35;
	localparam logic [CRD_W-1:0]  DMA_COST         = 16'h0110;
	localparam logic [TRN_W-1:0]  LOW_BANK_LAST    = 8'h30;
	localparam logic [TRN_W-1:0]  HIGH_BANK_OFFSET = 8'h4b;
	localparam logic [31:0]       CMD_MASK         = 32'h3fff0003;
	localparam logic [31:0]       CMD_BITS         = 32'h40000080;

	localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
	localparam logic [OP_W-1:0] OP_FIND    = 3'd1;
	localparam logic [OP_W-1:0] OP_FRAME   = 3'd2;
	localparam logic [OP_W-1:0] OP_CREDIT  = 3'd3;
	localparam logic [OP_W-1:0] OP_AGE     = 3'd4;
	localparam logic [OP_W-1:0] OP_TRIM    = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;
	localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;

	typedef struct packed {
		logic [BLK_W-1:0] block;
		logic [USE_W-1:0] uses;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef struct packed {
		logic   wr_en;
		entry_t wr_data;
		logic   match;
		logic   cand;
	} unit_res_t;

	function automatic logic [TRN_W-1:0] translate(input logic [TRN_W-1:0] idx);
		translate = idx + ((idx <= LOW_BANK_LAST) ? TRN_W'(1) : HIGH_BANK_OFFSET);
	endfunction

	function automatic logic [31:0] dma_cmd(input logic [TRN_W-1:0] t);
		logic [31:0] t32;
		t32 = 32'(t);
		dma_cmd = (((t32 << 25) | (t32 >> 5)) & CMD_MASK) | CMD_BITS;
	endfunction

endpackage

FILE: sv/vbsc_slot_ram.sv
// slot table memory with registered read and per-entry valid bits
module vbsc_slot_ram
	import vbsc_pkg::*;
#(
	parameter int DEPTH = SLOT_COUNT_DEF,
	parameter int IDX_W = $clog2(SLOT_COUNT_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t           mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	entry_t           rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: sv/vbsc_entry_unit.sv
// shared per-slot compare, add and update unit
module vbsc_entry_unit
	import vbsc_pkg::*;
#(
	parameter int IDX_W = $clog2(SLOT_COUNT_DEF)
) (
	input  logic [OP_W-1:0]  op,
	input  entry_t           entry,
	input  logic [BLK_W-1:0] num,
	input  logic [IDX_W-1:0] idx,
	input  logic [CFG_W-1:0] lim,
	input  logic [AGE_W-1:0] best_age,
	output unit_res_t        res
);

	logic in_range;

	always_comb begin
		in_range    = 32'(idx) < 32'(lim);
		res.wr_en   = 1'b0;
		res.wr_data = entry;
		res.match   = 1'b0;
		res.cand    = 1'b0;
		unique case (op)
			OP_LOAD: begin
				res.match = in_range && (entry.block == num);
				res.cand  = in_range && (entry.uses == '0) && (entry.age > best_age);
			end
			OP_FIND: begin
				res.match = in_range && (entry.block == num);
			end
			OP_FRAME: begin
				res.wr_en        = 1'b1;
				res.wr_data.uses = '0;
			end
			OP_AGE: begin
				res.wr_en       = (entry.uses == '0);
				res.wr_data.age = entry.age + AGE_W'(1);
			end
			OP_TRIM: begin
				res.wr_en   = !in_range;
				res.wr_data = '0;
			end
			OP_CLEAR: begin
				res.wr_en   = 1'b1;
				res.wr_data = '0;
			end
			default: begin
				res.wr_en = 1'b0;
			end
		endcase
	end

endmodule

FILE: sv/vram_block_slot_cache.sv
// top level: graphics block slot cache with sequential slot scan and dma credit
// load and find scan all slots, then pass through the commit state before the result is posted
// ops 2, 4, 5, 6 post the result after the scan; set credit, unknown op and load of block zero skip the scan
// throughput: one transaction at a time, the next is taken only when idle after the result
// reset clears the slot table through valid bits at once, plus credit and the configured slot limit
module vram_block_slot_cache
	import vbsc_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   op,
	input  logic [BLK_W-1:0]  block_number,
	input  logic [CRD_W-1:0]  dma_credit,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [TILE_W-1:0] tile_index,
	output logic              hit,
	output logic              dma_issued,
	output logic [15:0]       dma_cmd_high,
	output logic [15:0]       dma_cmd_low,
	output logic [CRD_W-1:0]  credit_left
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = IDX_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_COMMIT = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  lim_q;
	logic [CRD_W-1:0]  credit_q;
	logic [OP_W-1:0]   op_q;
	logic [BLK_W-1:0]  num_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pvalid_s1;
	logic [IDX_W-1:0]  pidx_s1;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [USE_W-1:0]  hit_uses_q;
	logic              best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [AGE_W-1:0]  best_age_q;
	logic [TILE_W-1:0] res_tile_q;
	logic              res_hit_q;
	logic              res_dma_q;
	logic [31:0]       res_cmd_q;
	logic              out_valid_q;
	logic [TILE_W-1:0] out_tile_q;
	logic              out_hit_q;
	logic              out_dma_q;
	logic [31:0]       out_cmd_q;
	logic [CRD_W-1:0]  out_credit_q;

	entry_t            rd_data;
	unit_res_t         ures;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic              commit_we;
	logic [IDX_W-1:0]  commit_addr;
	entry_t            commit_data;
	logic              scan_issue;
	logic              scan_done;
	logic [TRN_W-1:0]  hit_t;
	logic [TRN_W-1:0]  best_t;
	logic              do_claim;

	vbsc_slot_ram #(
		.DEPTH (SLOT_COUNT),
		.IDX_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (cnt_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	vbsc_entry_unit #(
		.IDX_W (IDX_W)
	) u_unit (
		.op       (op_q),
		.entry    (rd_data),
		.num      (num_q),
		.idx      (pidx_s1),
		.lim      (lim_q),
		.best_age (best_age_q),
		.res      (ures)
	);

	assign in_stall   = (state_q != ST_IDLE);
	assign scan_issue = (state_q == ST_SCAN) && (cnt_q < CNT_W'(SLOT_COUNT));
	assign scan_done  = (state_q == ST_SCAN) && (cnt_q == CNT_W'(SLOT_COUNT)) && !pvalid_s1;

	assign hit_t    = translate(TRN_W'(hit_idx_q));
	assign best_t   = translate(TRN_W'(best_idx_q));
	assign do_claim = (op_q == OP_LOAD) && !hit_q && best_q && (credit_q >= DMA_COST);

	always_comb begin
		commit_we   = 1'b0;
		commit_addr = hit_idx_q;
		commit_data = '0;
		if (state_q == ST_COMMIT && op_q == OP_LOAD) begin
			priority if (hit_q) begin
				commit_we         = 1'b1;
				commit_data.block = num_q;
				commit_data.uses  = hit_uses_q + USE_W'(1);
			end else if (do_claim) begin
				commit_we         = 1'b1;
				commit_addr       = best_idx_q;
				commit_data.block = num_q;
				commit_data.uses  = USE_W'(1);
			end else begin
				commit_we = 1'b0;
			end
		end
	end

	always_comb begin
		if (state_q == ST_COMMIT) begin
			wr_en   = commit_we;
			wr_addr = commit_addr;
			wr_data = commit_data;
		end else begin
			wr_en   = (state_q == ST_SCAN) && pvalid_s1 && ures.wr_en;
			wr_addr = pidx_s1;
			wr_data = ures.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lim_q       <= '0;
			credit_q    <= '0;
			cnt_q       <= '0;
			pvalid_s1   <= 1'b0;
			hit_q       <= 1'b0;
			best_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lim_q <= (cfg_wdata > MAX_IN_USE) ? MAX_IN_USE : cfg_wdata;
			end
			if (out_valid_q && !out_stall && state_q != ST_RESULT) begin
				out_valid_q <= 1'b0;
			end
			pvalid_s1 <= scan_issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q  <= '0;
						hit_q  <= 1'b0;
						best_q <= 1'b0;
						priority if (op == OP_CREDIT) begin
							credit_q <= dma_credit;
							state_q  <= ST_RESULT;
						end else if (op == OP_LOAD && block_number == '0) begin
							state_q <= ST_RESULT;
						end else if (op == OP_UNKNOWN) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (pvalid_s1 && ures.match && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (pvalid_s1 && ures.cand) begin
						best_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= (op_q == OP_LOAD || op_q == OP_FIND) ? ST_COMMIT : ST_RESULT;
					end
				end
				ST_COMMIT: begin
					if (do_claim) begin
						credit_q <= credit_q - DMA_COST;
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q       <= op;
			num_q      <= block_number;
			best_age_q <= '0;
			res_tile_q <= '0;
			res_hit_q  <= 1'b0;
			res_dma_q  <= 1'b0;
			res_cmd_q  <= '0;
		end
		pidx_s1 <= cnt_q[IDX_W-1:0];
		if (state_q == ST_SCAN && pvalid_s1) begin
			if (ures.match && !hit_q) begin
				hit_idx_q  <= pidx_s1;
				hit_uses_q <= rd_data.uses;
			end
			if (ures.cand) begin
				best_idx_q <= pidx_s1;
				best_age_q <= rd_data.age;
			end
		end
		if (state_q == ST_COMMIT) begin
			priority if (hit_q) begin
				res_tile_q <= {hit_t, 4'b0000};
				res_hit_q  <= 1'b1;
			end else if (do_claim) begin
				res_tile_q <= {best_t, 4'b0000};
				res_dma_q  <= 1'b1;
				res_cmd_q  <= dma_cmd(best_t);
			end else begin
				res_tile_q <= '0;
			end
		end
		if (state_q == ST_RESULT && (!out_valid_q || !out_stall)) begin
			out_tile_q   <= res_tile_q;
			out_hit_q    <= res_hit_q;
			out_dma_q    <= res_dma_q;
			out_cmd_q    <= res_cmd_q;
			out_credit_q <= credit_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign tile_index   = out_tile_q;
	assign hit          = out_hit_q;
	assign dma_issued   = out_dma_q;
	assign dma_cmd_high = out_cmd_q[31:16];
	assign dma_cmd_low  = out_cmd_q[15:0];
	assign credit_left  = out_credit_q;

endmodule
